// ===== design/binomial_coefficient_multiplicative_macros.svh =====
// Assertion macros for the binomial coefficient block checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BINOMIAL_COEFFICIENT_MULTIPLICATIVE_MACROS_SVH
`define BINOMIAL_COEFFICIENT_MULTIPLICATIVE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcm assertion failed");

// Next-cycle implication, disabled during reset.
`define BCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcm assertion failed");

`endif

// ===== design/bcm_pkg.sv =====
// Package for the binomial coefficient block: widths, default maximum n, state type.
// No dependencies.
`timescale 1ns / 1ps

package bcm_pkg;

  localparam int unsigned FIELD_W       = 6;
  localparam int unsigned VAL_W         = 64;
  localparam int unsigned PROD_W        = 70;
  localparam int unsigned MAX_N_DEFAULT = 63;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_DIV,
    S_FINISH
  } bcm_state_t;

endpackage

// ===== design/binomial_coefficient_multiplicative.sv =====
// Binomial coefficient C(n,k) by the multiplicative rule on one shared adder.
// Depends on bcm_pkg.
//
//   channel  signals                      payload
//   in       in_valid / in_stall          set_size[5:0], choose_count[5:0]
//   out      out_valid / out_stall        coefficient[63:0], step_count[5:0]
//
// Special cases (k = 0, k = n, k > n, n > MAX_N) go from accept straight to the result.
// Otherwise k steps: each step is a setup, a shift-add multiply and a restoring divide,
// all on one 71-bit adder.
// Reset clears the sequencer and the output valid; no clearing pass.
// A result waits in the output register while the next transaction is accepted.
`timescale 1ns / 1ps

module binomial_coefficient_multiplicative
  import bcm_pkg::*;
#(
  parameter int unsigned MAX_N = MAX_N_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FIELD_W-1:0]  set_size,
  input  logic [FIELD_W-1:0]  choose_count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [VAL_W-1:0]    coefficient,
  output logic [FIELD_W-1:0]  step_count
);

  localparam logic [FIELD_W:0] MAX_N_W  = (FIELD_W+1)'(MAX_N);
  localparam logic [2:0]       MUL_LAST = 3'(FIELD_W - 1);
  localparam logic [6:0]       DIV_LAST = 7'(PROD_W - 1);

  bcm_state_t state, state_next;

  logic [FIELD_W-1:0] n_reg;
  logic [FIELD_W-1:0] k_reg;
  logic [FIELD_W-1:0] i_reg;
  logic               special;
  logic [VAL_W-1:0]   value;
  logic [PROD_W-1:0]  mcand;
  logic [FIELD_W-1:0] mplier;
  logic [PROD_W-1:0]  acc;
  logic [2:0]         mcnt;
  logic [FIELD_W-1:0] rem;
  logic [PROD_W-1:0]  quo;
  logic [6:0]         dcnt;

  logic               zero_case;
  logic               one_case;
  logic               special_in;
  logic [FIELD_W:0]   rem_shift;
  logic [PROD_W-1:0]  op_a;
  logic [PROD_W-1:0]  op_b;
  logic               cin;
  logic [PROD_W:0]    sum;
  logic               ge;
  logic [PROD_W-1:0]  acc_upd;
  logic [PROD_W-1:0]  quo_next;
  logic               result_load;

  assign zero_case  = ({1'b0, set_size} > MAX_N_W) || (choose_count > set_size);
  assign one_case   = (choose_count == '0) || (choose_count == set_size);
  assign special_in = zero_case || one_case;

  assign rem_shift = {rem, quo[PROD_W-1]};
  assign sum       = {1'b0, op_a} + {1'b0, op_b} + {{PROD_W{1'b0}}, cin};
  assign ge        = sum[PROD_W];
  assign acc_upd   = mplier[0] ? sum[PROD_W-1:0] : acc;
  assign quo_next  = {quo[PROD_W-2:0], ge};

  always_comb begin
    in_stall    = (state != S_IDLE);
    result_load = (state == S_FINISH) && (!out_valid || !out_stall);
    op_a        = acc;
    op_b        = mcand;
    cin         = 1'b0;
    case (state)
      S_DIV: begin
        op_a = {{(PROD_W-FIELD_W-1){1'b0}}, rem_shift};
        op_b = ~{{(PROD_W-FIELD_W){1'b0}}, i_reg};
        cin  = 1'b1;
      end
      default: begin
        op_a = acc;
        op_b = mcand;
        cin  = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = special_in ? S_FINISH : S_LOAD;
      end
      S_LOAD:   state_next = S_MUL;
      S_MUL: begin
        if (mcnt == MUL_LAST) state_next = S_DIV;
      end
      S_DIV: begin
        if (dcnt == DIV_LAST) state_next = (i_reg == k_reg) ? S_FINISH : S_LOAD;
      end
      S_FINISH: begin
        if (result_load) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          n_reg   <= set_size;
          k_reg   <= choose_count;
          i_reg   <= FIELD_W'(1);
          special <= special_in;
          value   <= zero_case ? '0 : VAL_W'(1);
        end
      end
      S_LOAD: begin
        mcand  <= {{(PROD_W-VAL_W){1'b0}}, value};
        mplier <= n_reg - i_reg + FIELD_W'(1);
        acc    <= '0;
        mcnt   <= '0;
      end
      S_MUL: begin
        acc    <= acc_upd;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        mcnt   <= mcnt + 3'd1;
        if (mcnt == MUL_LAST) begin
          quo  <= acc_upd;
          rem  <= '0;
          dcnt <= '0;
        end
      end
      S_DIV: begin
        rem  <= ge ? sum[FIELD_W-1:0] : rem_shift[FIELD_W-1:0];
        quo  <= quo_next;
        dcnt <= dcnt + 7'd1;
        if (dcnt == DIV_LAST) begin
          value <= quo_next[VAL_W-1:0];
          i_reg <= i_reg + FIELD_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      coefficient <= value;
      step_count  <= special ? '0 : k_reg;
    end
  end

endmodule

// ===== design/bcm_checker.sv =====
// Port-level checker for the binomial coefficient block, bound into binomial_coefficient_multiplicative.
// Depends on bcm_pkg and binomial_coefficient_multiplicative_macros.svh.
`timescale 1ns / 1ps
`include "binomial_coefficient_multiplicative_macros.svh"

module bcm_checker
  import bcm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [VAL_W-1:0]   coefficient,
  input logic [FIELD_W-1:0] step_count
);

  `BCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `BCM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `BCM_ASSERT_IMPL(a_steps_nonzero_value, out_valid && (step_count != '0), coefficient != '0)
  `BCM_ASSERT_IMPL(a_special_value, out_valid && (step_count == '0), coefficient <= VAL_W'(1))

endmodule

bind binomial_coefficient_multiplicative bcm_checker u_bcm_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for binomial_coefficient_multiplicative: directed and random
// (n, k) transactions with random source gaps and sink stalls, checked against C(n,k).
// Depends on bcm_pkg and the binomial_coefficient_multiplicative RTL.
`timescale 1ns / 1ps

module tb_top;
  import bcm_pkg::*;

  localparam int unsigned MAX_N       = MAX_N_DEFAULT;
  localparam int unsigned RANDOM_CNT  = 112;
  localparam int unsigned DRAIN_CYC   = 5000;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct {
    logic [FIELD_W-1:0] n;
    logic [FIELD_W-1:0] k;
  } choice_t;

  typedef struct {
    logic [FIELD_W-1:0] n;
    logic [FIELD_W-1:0] k;
    logic [VAL_W-1:0]   coef;
    logic [FIELD_W-1:0] steps;
  } binom_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FIELD_W-1:0] set_size = '0;
  logic [FIELD_W-1:0] choose_count = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [VAL_W-1:0]   coefficient;
  logic [FIELD_W-1:0] step_count;

  choice_t       pending_choices[$];
  binom_result_t expected_binoms[$];

  int unsigned total_items;
  int unsigned sent_cnt;
  int unsigned checked_cnt;
  int unsigned special_cnt;
  int unsigned stepped_cnt;
  int unsigned widest_k;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  int unsigned src_idle;
  int unsigned src_calm;
  int unsigned sink_hold;

  binomial_coefficient_multiplicative #(.MAX_N(MAX_N)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .set_size     (set_size),
    .choose_count (choose_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .coefficient  (coefficient),
    .step_count   (step_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic binom_result_t binom_predict(logic [FIELD_W-1:0] n,
                                                  logic [FIELD_W-1:0] k);
    binom_result_t  r;
    logic [PROD_W-1:0] prod;
    logic [VAL_W-1:0]  value;
    r.n = n;
    r.k = k;
    r.steps = '0;
    if (int'(n) > int'(MAX_N) || k > n) begin
      r.coef = '0;
    end else if (k == 0 || k == n) begin
      r.coef = 64'd1;
    end else begin
      value = 64'd1;
      for (int unsigned i = 1; i <= k; i++) begin
        prod  = PROD_W'(value) * PROD_W'(n - i + 1);
        value = VAL_W'(prod / PROD_W'(i));
      end
      r.coef  = value;
      r.steps = k;
    end
    return r;
  endfunction

  function automatic choice_t random_choice();
    choice_t     c;
    int unsigned mode;
    int unsigned n;
    int unsigned k;
    mode = $urandom_range(0, 9);
    n = $urandom_range(0, 63);
    if (mode <= 5) begin
      k = $urandom_range(0, (n < 8) ? n : 8);
    end else if (mode == 6) begin
      k = $urandom_range(0, (n < 16) ? n : 16);
    end else if (mode == 7) begin
      k = $urandom_range(0, n);
    end else if (mode == 8) begin
      if (n == 63) n = $urandom_range(0, 62);
      k = $urandom_range(n + 1, 63);
    end else begin
      k = $urandom_range(0, 1) ? n : 0;
    end
    c.n = FIELD_W'(n);
    c.k = FIELD_W'(k);
    return c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  // Source: hold the payload until accepted, then idle for a random gap.
  always @(posedge clk) begin
    choice_t c;
    if (rst) begin
      in_valid <= 1'b0;
      src_idle = 0;
      src_calm = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_binoms.insert(expected_binoms.size(),
                               binom_predict(set_size, choose_count));
        sent_cnt++;
        if (src_calm > 0) begin
          src_calm--;
          src_idle = 0;
        end else begin
          src_idle = pick_gap();
          if ($urandom_range(0, 19) == 0) src_calm = $urandom_range(5, 15);
        end
      end
      if (!in_valid || !in_stall) begin
        if (src_idle > 0 || pending_choices.size() == 0) begin
          in_valid <= 1'b0;
          if (src_idle > 0) src_idle--;
        end else begin
          c = pending_choices.pop_front();
          set_size     <= c.n;
          choose_count <= c.k;
          in_valid     <= 1'b1;
        end
      end
    end
  end

  // Sink: check each transaction against the oldest prediction, stall at random.
  always @(posedge clk) begin
    binom_result_t e;
    if (rst) begin
      out_stall <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_binoms.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("tb_top: unexpected result coefficient=%0d step_count=%0d",
                     coefficient, step_count);
        end else begin
          e = expected_binoms.pop_front();
          checked_cnt++;
          if (e.steps == 0) special_cnt++;
          else stepped_cnt++;
          if (32'(e.steps) > widest_k) widest_k = 32'(e.steps);
          if (coefficient !== e.coef || step_count !== e.steps) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
              $display("tb_top: mismatch n=%0d k=%0d coefficient exp %0d got %0d, %s%0d got %0d",
                       e.n, e.k, e.coef, coefficient, "step_count exp ", e.steps,
                       step_count);
          end
        end
      end
      if (sink_hold > 0) begin
        out_stall <= 1'b1;
        sink_hold--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                : $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles, %0d of %0d checked",
               cycle_cnt, checked_cnt, total_items);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    choice_t c;
    int unsigned directed_n[18] = '{0, 1, 1, 63, 63, 63, 63, 63, 63, 62, 10, 2, 5, 0, 62,
                                    0, 33, 63};
    int unsigned directed_k[18] = '{0, 0, 1, 0, 63, 1, 62, 31, 32, 31, 5, 1, 7, 63, 63,
                                    1, 17, 2};
    for (int i = 0; i < 18; i++) begin
      c.n = FIELD_W'(directed_n[i]);
      c.k = FIELD_W'(directed_k[i]);
      pending_choices.insert(pending_choices.size(), c);
    end
    for (int i = 0; i < RANDOM_CNT; i++)
      pending_choices.insert(pending_choices.size(), random_choice());
    total_items = pending_choices.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (sent_cnt < total_items || expected_binoms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("tb_top: %0d transactions checked, %0d special cases and %0d stepped, largest k %0d",
             checked_cnt, special_cnt, stepped_cnt, widest_k);
    $display("tb_top: %0d mismatches in %0d cycles", mismatch_cnt, cycle_cnt);
    if (mismatch_cnt == 0 && expected_binoms.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/bcm_pkg.sv
design/binomial_coefficient_multiplicative.sv
design/bcm_checker.sv
dv/tb_top.sv
